// ===== hdl/isl_pkg.sv =====
// Shared types and constants for the indexed shift list.
`default_nettype none

package isl_pkg;

	localparam int VAL_W = 32;
	localparam int REQ_W = 3;

	typedef enum logic [REQ_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_READ   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic ins;
		logic ers;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/isl_cell.sv =====
// One storage cell of the list: holds an element and shifts with its neighbours.
`default_nettype none

module isl_cell
	import isl_pkg::*;
#(
	parameter int ELEM_BITS = 32,
	parameter int PW        = 7,
	parameter int INDEX     = 0
) (
	input  wire logic                 clk,
	input  wire cell_ctl_t            ctl,
	input  wire logic [PW-1:0]        pos,
	input  wire logic [ELEM_BITS-1:0] val,
	input  wire logic [ELEM_BITS-1:0] below,
	input  wire logic [ELEM_BITS-1:0] above,
	output logic      [ELEM_BITS-1:0] data,
	output logic      [ELEM_BITS-1:0] rd
);

	logic [ELEM_BITS-1:0] data_q;
	logic                 hit;
	logic                 upper;

	assign hit   = (PW'(INDEX) == pos);
	assign upper = (PW'(INDEX) > pos);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (hit) begin
				data_q <= val;
			end else if (upper) begin
				data_q <= below;
			end
		end else if (ctl.ers && (hit || upper)) begin
			data_q <= above;
		end
	end

	assign data = data_q;
	assign rd   = hit ? data_q : '0;

endmodule

`default_nettype wire

// ===== hdl/isl_or_tree.sv =====
// Registered eight-way OR tree that gathers the selected cell onto one word.
`default_nettype none

module isl_or_tree #(
	parameter int N = 64,
	parameter int W = 32,
	localparam int LVLS = ($clog2(N) + 2) / 3,
	localparam int NPAD = 8 ** LVLS
) (
	input  wire logic         clk,
	input  wire logic [W-1:0] leaf [N],
	output logic      [W-1:0] root
);

	function automatic int lvl_off(input int k);
		int s;
		s = 0;
		for (int j = 1; j < k; j++) begin
			s += 8 ** (LVLS - j);
		end
		return s;
	endfunction

	localparam int TOT = lvl_off(LVLS + 1);

	logic [W-1:0] pad    [NPAD];
	logic [W-1:0] node_d [TOT];
	logic [W-1:0] node_q [TOT];

	always_comb begin
		for (int i = 0; i < NPAD; i++) begin
			pad[i] = (i < N) ? leaf[i] : '0;
		end
	end

	always_comb begin
		logic [W-1:0] acc;
		for (int n = 0; n < NPAD / 8; n++) begin
			acc = '0;
			for (int c = 0; c < 8; c++) begin
				acc |= pad[8*n + c];
			end
			node_d[n] = acc;
		end
		for (int k = 2; k <= LVLS; k++) begin
			for (int n = 0; n < 8 ** (LVLS - k); n++) begin
				acc = '0;
				for (int c = 0; c < 8; c++) begin
					acc |= node_q[lvl_off(k - 1) + 8*n + c];
				end
				node_d[lvl_off(k) + n] = acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
	end

	assign root = node_q[TOT-1];

endmodule

`default_nettype wire

// ===== hdl/indexed_shift_list.sv =====
// Indexed shift list: ordered element store with insert/erase by index.
//
// Input stream s_*: one beat per request. s_tuser carries the request type
// (push_back, pop_back, insert, erase, read_at, clear); s_tdata carries the
// position (low PW bits) and the element value above it.
// Output stream m_*: one beat per request. m_tuser[0] is the success flag;
// m_tdata carries the element read (low 32 bits, zero unless a read_at
// succeeded) and the element count after the request above it.
// The elements sit in a row of cells; an insert or erase shifts every cell
// above the position by one place at once. A read_at gathers the
// addressed cell through a registered eight-way OR tree of
// LVLS = ceil(log8(DEPTH)) levels (2 for DEPTH 64).
// A request runs through the EXEC and WALK states (and EMIT while the receiver
// stalls) before its result is loaded into the output register; s_tready is high
// only while idle, so no new request is taken until the last one is loaded.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the block holds before loading it.
// Reset empties the list (count zero); cell contents are not cleared.
`default_nettype none

module indexed_shift_list
	import isl_pkg::*;
#(
	parameter int DEPTH     = 64,
	parameter int ELEM_BITS = 32,
	localparam int PW    = $clog2(DEPTH + 1),
	localparam int IN_W  = ((VAL_W + PW + 7) / 8) * 8,
	localparam int OUT_W = ((VAL_W + PW + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // position, elem_value
	input  wire logic [REQ_W-1:0] s_tuser,  // req_type
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [OUT_W-1:0] m_tdata,  // read_value, count
	output logic      [0:0]       m_tuser   // ok
);

	localparam int LVLS = ($clog2(DEPTH) + 2) / 3;
	localparam int CW   = (LVLS > 1) ? $clog2(LVLS) : 1;

	state_t               state_q, state_d;
	op_t                  op_q;
	logic [PW-1:0]        pos_q;
	logic [ELEM_BITS-1:0] val_q;
	logic [PW-1:0]        fill_q, fill_d;
	logic                 rd_en_q;
	logic                 ok_q;
	logic [CW-1:0]        cnt_q;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;
	logic                 m_ok_q;

	logic                 ok_d;
	logic                 ld_out;
	logic                 out_free;
	logic                 full;
	logic                 empty;
	logic [PW-1:0]        cell_pos;
	cell_ctl_t            ctl;
	logic [63:0]          val_ext;
	logic [63:0]          root_ext;
	logic [VAL_W-1:0]     rd_val;

	logic [ELEM_BITS-1:0] cell_data [DEPTH];
	logic [ELEM_BITS-1:0] cell_rd   [DEPTH];
	logic [ELEM_BITS-1:0] root;

	assign full     = (fill_q == PW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign out_free = !m_tvalid_q || m_tready;
	assign val_ext  = 64'(s_tdata[PW +: VAL_W]);

	always_comb begin
		ok_d   = 1'b0;
		fill_d = fill_q;
		unique case (op_q)
			OP_PUSH: begin
				ok_d   = !full;
				fill_d = fill_q + 1'b1;
			end
			OP_POP: begin
				ok_d   = !empty;
				fill_d = fill_q - 1'b1;
			end
			OP_INSERT: begin
				ok_d   = (pos_q <= fill_q) && !full;
				fill_d = fill_q + 1'b1;
			end
			OP_ERASE: begin
				ok_d   = (pos_q < fill_q);
				fill_d = fill_q - 1'b1;
			end
			OP_READ: begin
				ok_d = (pos_q < fill_q);
			end
			OP_CLEAR: begin
				ok_d   = 1'b1;
				fill_d = '0;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	assign cell_pos = (op_q == OP_PUSH) ? fill_q : pos_q;

	always_comb begin
		ctl.ins = (state_q == ST_EXEC) && ok_d && (op_q == OP_PUSH || op_q == OP_INSERT);
		ctl.ers = (state_q == ST_EXEC) && ok_d && (op_q == OP_ERASE);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		isl_cell #(
			.ELEM_BITS (ELEM_BITS),
			.PW        (PW),
			.INDEX     (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (cell_pos),
			.val   (val_q),
			.below (cell_data[(i == 0) ? 0 : i - 1]),
			.above (cell_data[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
			.data  (cell_data[i]),
			.rd    (cell_rd[i])
		);
	end

	isl_or_tree #(
		.N (DEPTH),
		.W (ELEM_BITS)
	) u_tree (
		.clk  (clk),
		.leaf (cell_rd),
		.root (root)
	);

	assign root_ext = 64'(root);
	assign rd_val   = rd_en_q ? root_ext[VAL_W-1:0] : '0;

	always_comb begin
		state_d = state_q;
		ld_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (cnt_q == CW'(LVLS - 1)) begin
					if (out_free) begin
						ld_out  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					ld_out  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			rd_en_q    <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				cnt_q   <= '0;
				rd_en_q <= ok_d && (op_q == OP_READ);
				if (ok_d) begin
					fill_q <= fill_d;
				end
			end else if (state_q == ST_WALK) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ld_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= op_t'(s_tuser);
			pos_q <= s_tdata[PW-1:0];
			val_q <= val_ext[ELEM_BITS-1:0];
		end
		if (state_q == ST_EXEC) begin
			ok_q <= ok_d;
		end
		if (ld_out) begin
			m_tdata_q <= OUT_W'({fill_q, rd_val});
			m_ok_q    <= ok_q;
		end
	end

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_ok_q;

endmodule

`default_nettype wire

// ===== hdl/isl_chk.sv =====
// Port-level checks for the indexed shift list, bound to the top level.
`default_nettype none

module isl_chk
	import isl_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int PW    = $clog2(DEPTH + 1),
	localparam int OUT_W = ((VAL_W + PW + 7) / 8) * 8
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic [0:0]       m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while one is in flight");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[VAL_W-1:0] == '0)
		else $error("rejected request returned data");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[VAL_W +: PW] <= PW'(DEPTH))
		else $error("count beyond depth");

endmodule

bind indexed_shift_list isl_chk #(.DEPTH(DEPTH)) u_isl_chk (.*);

`default_nettype wire

// ===== verif/tb_indexed_shift_list.sv =====
// Self-checking testbench for indexed_shift_list: directed edge cases, then random request streams.
`timescale 1ns / 100ps

module tb_indexed_shift_list
	import isl_pkg::*;
();

	localparam int DEPTH       = 64;
	localparam int POS_W       = $clog2(DEPTH + 1);
	localparam int IN_W        = ((VAL_W + POS_W + 7) / 8) * 8;
	localparam int OUT_W       = ((VAL_W + POS_W + 7) / 8) * 8;
	localparam int RAND_ITEMS  = 1950;
	localparam int CYCLE_LIMIT = 1500000;

	localparam logic [REQ_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [REQ_W-1:0] OP_RSVD7 = 3'd7;

	typedef struct {
		bit               ok;
		logic [VAL_W-1:0] rd;
		logic [POS_W-1:0] cnt;
	} reply_t;

	class list_tracker;
		logic [VAL_W-1:0] cells [DEPTH];
		int               fill;
		reply_t           due [$];
		int               fails;
		int               accepted;
		int               refused;
		int               peak;
		int               reads_hit;

		function void take_request(logic [REQ_W-1:0] kind, int pos, logic [VAL_W-1:0] val);
			reply_t r;
			r.ok = 1'b0;
			r.rd = '0;
			case (kind)
				OP_PUSH: begin
					if (fill < DEPTH) begin
						cells[fill] = val;
						fill++;
						r.ok = 1'b1;
					end
				end
				OP_POP: begin
					if (fill > 0) begin
						fill--;
						r.ok = 1'b1;
					end
				end
				OP_INSERT: begin
					if (pos <= fill && fill < DEPTH) begin
						for (int i = fill; i > pos; i--)
							cells[i] = cells[i-1];
						cells[pos] = val;
						fill++;
						r.ok = 1'b1;
					end
				end
				OP_ERASE: begin
					if (pos < fill) begin
						for (int i = pos; i + 1 < fill; i++)
							cells[i] = cells[i+1];
						fill--;
						r.ok = 1'b1;
					end
				end
				OP_READ: begin
					if (pos < fill) begin
						r.rd = cells[pos];
						r.ok = 1'b1;
						reads_hit++;
					end
				end
				OP_CLEAR: begin
					fill = 0;
					r.ok = 1'b1;
				end
				default: ;
			endcase
			r.cnt = fill[POS_W-1:0];
			accepted++;
			if (!r.ok)
				refused++;
			if (fill > peak)
				peak = fill;
			due.push_back(r);
		endfunction

		function void match_reply(bit ok, logic [VAL_W-1:0] rd, logic [POS_W-1:0] cnt);
			reply_t r;
			if (due.size() == 0) begin
				$error("result beat with nothing outstanding");
				fails++;
				return;
			end
			r = due.pop_front();
			if (ok !== r.ok) begin
				$error("ok: expected %0d, got %0d", r.ok, ok);
				fails++;
			end
			if (rd !== r.rd) begin
				$error("read_value: expected %h, got %h", r.rd, rd);
				fails++;
			end
			if (cnt !== r.cnt) begin
				$error("count: expected %0d, got %0d", r.cnt, cnt);
				fails++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;  // position, elem_value
	logic [REQ_W-1:0] s_tuser;  // req_type
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;  // read_value, count
	logic [0:0]       m_tuser;  // ok

	list_tracker tracker = new;
	bit          calm;
	int          cycles;

	indexed_shift_list #(.DEPTH(DEPTH), .ELEM_BITS(VAL_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[indexed_shift_list] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_reply(m_tuser[0], m_tdata[VAL_W-1:0], m_tdata[VAL_W +: POS_W]);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver back-pressure
	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			n = $urandom_range(1, 30);
			repeat (n) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end
			n = pick_gap();
			repeat (n) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
		end
	end

	task automatic issue(input logic [REQ_W-1:0] kind, input int pos, input logic [VAL_W-1:0] val);
		int gap;
		logic [POS_W-1:0] p;
		gap = pick_gap();
		p = pos[POS_W-1:0];
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(IN_W-VAL_W-POS_W){1'b0}}, val, p};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.take_request(kind, pos, val);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (tracker.due.size() != 0);
	endtask

	task automatic directed_part();
		issue(OP_POP, 0, 32'h0);
		issue(OP_READ, 0, 32'h0);
		issue(OP_ERASE, 0, 32'h0);
		issue(OP_INSERT, 1, 32'h1111_1111);
		issue(OP_INSERT, 0, 32'h0);
		issue(OP_PUSH, 0, 32'hFFFF_FFFF);
		issue(OP_INSERT, 2, 32'hA5A5_5A5A);
		issue(OP_INSERT, 1, 32'h1234_5678);
		for (int i = 0; i < 4; i++)
			issue(OP_READ, i, 32'h0);
		issue(OP_ERASE, 1, 32'h0);
		issue(OP_READ, 64, 32'h0);
		issue(OP_RSVD6, 0, 32'hDEAD_BEEF);
		issue(OP_RSVD7, 63, 32'hFFFF_FFFF);
		issue(OP_CLEAR, 0, 32'h0);
		issue(OP_READ, 0, 32'h0);
		// fill to the brim, then probe the full case
		for (int i = 0; i < DEPTH; i++)
			issue(OP_PUSH, 0, $urandom);
		issue(OP_PUSH, 0, 32'h5555_5555);
		issue(OP_INSERT, 64, 32'h5555_5555);
		issue(OP_INSERT, 0, 32'h5555_5555);
		issue(OP_READ, 63, 32'h0);
		issue(OP_ERASE, 0, 32'h0);
		issue(OP_INSERT, 63, 32'hCAFE_F00D);
		issue(OP_READ, 63, 32'h0);
		issue(OP_ERASE, 63, 32'h0);
		issue(OP_POP, 0, 32'h0);
		issue(OP_CLEAR, 0, 32'h0);
	endtask

	task automatic random_part();
		int left, r, pos, f, hi_mark, lo_mark;
		bit grow;
		logic [REQ_W-1:0] kind;
		logic [VAL_W-1:0] val;
		left = RAND_ITEMS;
		grow = 1'b1;
		hi_mark = DEPTH;
		lo_mark = 0;
		while (left > 0) begin
			f = tracker.fill;
			if (grow && f >= hi_mark) begin
				grow = 1'b0;
				lo_mark = $urandom_range(0, f / 2);
			end else if (!grow && f <= lo_mark) begin
				grow = 1'b1;
				hi_mark = ($urandom_range(0, 2) == 0) ? DEPTH : $urandom_range(4, DEPTH);
			end
			if (left % 250 == 0)
				calm = ~calm;
			if (left % 400 == 0)
				drain();

			r = $urandom_range(0, 99);
			if (r < 1)
				kind = OP_CLEAR;
			else if (r < 2)
				kind = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
			else if (r < 22)
				kind = OP_READ;
			else if (grow)
				kind = (r < 52) ? OP_PUSH : (r < 82) ? OP_INSERT : (r < 91) ? OP_POP : OP_ERASE;
			else
				kind = (r < 32) ? OP_PUSH : (r < 42) ? OP_INSERT : (r < 72) ? OP_POP : OP_ERASE;

			r = $urandom_range(0, 9);
			if (r == 0)
				pos = $urandom_range(0, DEPTH);
			else if (r == 1)
				pos = 0;
			else if (kind == OP_INSERT)
				pos = (r == 2) ? f : $urandom_range(0, f);
			else if (f == 0)
				pos = 0;
			else
				pos = (r == 2) ? f - 1 : $urandom_range(0, f - 1);

			r = $urandom_range(0, 15);
			val = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;

			issue(kind, pos, val);
			if (kind != OP_RSVD6 && kind != OP_RSVD7)
				left--;
		end
	endtask

	initial begin
		cycles   = 0;
		calm     = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_part();
		drain();
		random_part();

		drain();
		repeat (8) @(posedge clk);

		$display("%0d requests checked, %0d rejected, %0d reads returned data, peak fill %0d of %0d",
			tracker.accepted, tracker.refused, tracker.reads_hit, tracker.peak, DEPTH);
		if (tracker.fails == 0 && tracker.due.size() == 0)
			$display("[indexed_shift_list] OK");
		else
			$display("[indexed_shift_list] ERROR");
		$finish;
	end

endmodule
